@@ hw/rtl/tlc_pkg.sv @@
// Shared types and constants for the traffic light controller.
package tlc_pkg;

   // potentiometer sample and millisecond widths
   localparam int unsigned POT_BITS = 10;
   localparam int unsigned POT_FULL = (1 << POT_BITS) - 1;
   localparam int unsigned MS_W     = 12;
   localparam int unsigned PROD_W   = POT_BITS + MS_W;
   localparam int unsigned SUM_W    = PROD_W + 1;
   localparam int unsigned EST_W    = SUM_W - POT_BITS;

   // ms / 50 as (ms * 1311) >> 16, exact for any 12-bit ms
   localparam int unsigned RECIP_W     = 11;
   localparam int unsigned RECIP_50    = 1311;
   localparam int unsigned RECIP_SHIFT = 16;
   localparam int unsigned Q50_W       = 7;

   localparam int unsigned TICKS_W = 10;
   localparam int unsigned HOLD_W  = 10;
   localparam int unsigned ALERT_W = 4;
   localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

   // configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = MS_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_MIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL_MAX = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESS   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NIGHT_HALF   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALERT_PERIOD = 3'd4;

   localparam logic [MS_W-1:0]    RST_INTERVAL_MIN = 12'd200;
   localparam logic [MS_W-1:0]    RST_INTERVAL_MAX = 12'd2000;
   localparam logic [HOLD_W-1:0]  RST_LONG_PRESS   = 10'd200;
   localparam logic [TICKS_W-1:0] RST_NIGHT_HALF   = 10'd50;
   localparam logic [ALERT_W-1:0] RST_ALERT_PERIOD = 4'd5;

   // in night mode PH_GREEN is the lit half and PH_YELLOW the dark half
   typedef enum logic [1:0] {
      PH_GREEN  = 2'd0,
      PH_YELLOW = 2'd1,
      PH_RED    = 2'd2
   } phase_type;

   typedef struct packed {
      logic                button_pressed;
      logic [POT_BITS-1:0] pot_level;
   } tlc_req_type;

   typedef struct packed {
      logic        red_on;
      logic        yellow_on;
      logic        green_on;
      logic        night_active;
      logic        is_paused;
      logic [15:0] completed_cycles;
      logic        cycle_alert;
   } tlc_rsp_type;

   // tick after phase-length lookup
   typedef struct packed {
      logic               btn;
      logic [TICKS_W-1:0] ticks;
   } tlc_len_type;

endpackage

@@ hw/rtl/tlc_len_pipe.sv @@
// Pipeline that turns a potentiometer sample into a phase length in ticks.
module tlc_len_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  tlc_pkg::tlc_req_type       in_data,
   input  logic [tlc_pkg::MS_W-1:0]   min_ms,
   input  logic [tlc_pkg::MS_W-1:0]   max_ms,
   output logic                       out_valid,
   input  logic                       out_ready,
   output tlc_pkg::tlc_len_type       out_data
);
   import tlc_pkg::*;

   logic                 a_v_ff;
   tlc_req_type          a_req_ff;
   logic                 b_v_ff;
   logic                 b_btn_ff;
   logic                 b_neg_ff;
   logic [PROD_W-1:0]    b_prod_ff;
   logic                 c_v_ff;
   logic                 c_btn_ff;
   logic [MS_W-1:0]      c_ms_ff;
   logic                 d_v_ff;
   tlc_len_type          d_data_ff;

   logic                 rdy_a, rdy_b, rdy_c, rdy_d;

   logic [MS_W:0]        diff;
   logic                 neg;
   logic [MS_W-1:0]      mag;
   logic [PROD_W-1:0]    prod;

   logic [SUM_W-1:0]     sum;
   logic [EST_W-1:0]     est;
   logic [SUM_W-1:0]     est_x_full;
   logic [SUM_W-1:0]     rem;
   logic [EST_W-1:0]     quo;
   logic [MS_W+1:0]      ms_s;
   logic [MS_W-1:0]      ms_in;

   logic [MS_W+RECIP_W-1:0] scaled;
   logic [Q50_W-1:0]        q50;
   logic [TICKS_W-1:0]      ticks_in;

   assign rdy_d    = !d_v_ff || out_ready;
   assign rdy_c    = !c_v_ff || rdy_d;
   assign rdy_b    = !b_v_ff || rdy_c;
   assign rdy_a    = !a_v_ff || rdy_b;
   assign in_ready = rdy_a;

   // stage A: signed span times sample, as sign and magnitude
   assign diff = {1'b0, max_ms} - {1'b0, min_ms};
   assign neg  = diff[MS_W];
   assign mag  = neg ? MS_W'(-diff) : diff[MS_W-1:0];
   assign prod = PROD_W'(a_req_ff.pot_level) * PROD_W'(mag);

   // stage B: divide by full scale; x/(2^n-1) ~ (x + x>>n + x>>2n) >> n, low by at most one
   assign sum = SUM_W'(b_prod_ff) + SUM_W'(b_prod_ff >> POT_BITS)
              + SUM_W'(b_prod_ff >> (2 * POT_BITS));
   assign est        = sum[SUM_W-1:POT_BITS];
   assign est_x_full = {est, POT_BITS'(0)} - SUM_W'(est);
   assign rem        = SUM_W'(b_prod_ff) - est_x_full;
   assign quo        = est + EST_W'(rem >= SUM_W'(POT_FULL));
   assign ms_s       = b_neg_ff ? ((MS_W+2)'(min_ms) - (MS_W+2)'(quo[MS_W-1:0]))
                                : ((MS_W+2)'(min_ms) + (MS_W+2)'(quo[MS_W-1:0]));
   assign ms_in      = ms_s[MS_W+1] ? '0 : ms_s[MS_W-1:0];

   // stage C: whole 50 ms steps, five ticks each
   assign scaled   = (MS_W+RECIP_W)'(c_ms_ff) * (MS_W+RECIP_W)'(RECIP_50);
   assign q50      = scaled[RECIP_SHIFT +: Q50_W];
   assign ticks_in = TICKS_W'({q50, 2'b00}) + TICKS_W'(q50);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
         d_v_ff <= 1'b0;
      end else begin
         if (rdy_a) a_v_ff <= in_valid;
         if (rdy_b) b_v_ff <= a_v_ff;
         if (rdy_c) c_v_ff <= b_v_ff;
         if (rdy_d) d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         a_req_ff <= in_data;
      end
      if (rdy_b && a_v_ff) begin
         b_btn_ff  <= a_req_ff.button_pressed;
         b_neg_ff  <= neg;
         b_prod_ff <= prod;
      end
      if (rdy_c && b_v_ff) begin
         c_btn_ff <= b_btn_ff;
         c_ms_ff  <= ms_in;
      end
      if (rdy_d && c_v_ff) begin
         d_data_ff.btn   <= c_btn_ff;
         d_data_ff.ticks <= ticks_in;
      end
   end

   assign out_valid = d_v_ff;
   assign out_data  = d_data_ff;

endmodule

@@ hw/rtl/traffic_light_controller.sv @@
// Throughput: one tick per cycle while rsp_ready keeps the output moving; the
// phase-length pipeline (multiply, divide by full scale, divide by 50) and the
// output register each hold one item.
// The light state updates once per tick as it enters the output register.
// Reset (synchronous, active high) restores the register defaults, starts at
// green with its length loaded on the first running tick, and empties the pipe.
module traffic_light_controller #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tlc_pkg::tlc_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tlc_pkg::tlc_rsp_type              rsp_data,
   input  logic                              csr_we,
   input  logic [tlc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tlc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tlc_pkg::*;

   logic [MS_W-1:0]       min_ff, max_ff;
   logic [HOLD_W-1:0]     long_ff;
   logic [TICKS_W-1:0]    nhalf_ff;
   logic [ALERT_W-1:0]    aper_ff;

   phase_type             phase_ff, phase_in;
   logic                  fresh_ff, fresh_in;
   logic [TICKS_W-1:0]    ticks_ff, ticks_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic                  night_ff, night_in;
   logic                  pause_ff, pause_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [ALERT_W-1:0]    acnt_ff, acnt_in;
   logic                  alert_in;

   logic                  rsp_valid_ff;
   tlc_rsp_type           rsp_data_ff, rsp_in;

   logic                  len_valid, len_ready;
   tlc_len_type           len_data;
   logic                  rdy_o, take;

   phase_type             run_phase;
   logic [TICKS_W-1:0]    load_ticks, cur_ticks;
   logic [ALERT_W-1:0]    period, acnt_next;
   logic                  lamp_en;
   logic [31:0]           cnt_wide;

   tlc_len_pipe u_len (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .min_ms    (min_ff),
      .max_ms    (max_ff),
      .out_valid (len_valid),
      .out_ready (len_ready),
      .out_data  (len_data)
   );

   assign rdy_o     = !rsp_valid_ff || rsp_ready;
   assign len_ready = rdy_o;
   assign take      = len_valid && rdy_o;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= RST_INTERVAL_MIN;
         max_ff   <= RST_INTERVAL_MAX;
         long_ff  <= RST_LONG_PRESS;
         nhalf_ff <= RST_NIGHT_HALF;
         aper_ff  <= RST_ALERT_PERIOD;
      end else if (csr_we) begin
         case (csr_index)
            CSR_INTERVAL_MIN: min_ff   <= csr_wdata[MS_W-1:0];
            CSR_INTERVAL_MAX: max_ff   <= csr_wdata[MS_W-1:0];
            CSR_LONG_PRESS:   long_ff  <= csr_wdata[HOLD_W-1:0];
            CSR_NIGHT_HALF:   nhalf_ff <= csr_wdata[TICKS_W-1:0];
            CSR_ALERT_PERIOD: aper_ff  <= csr_wdata[ALERT_W-1:0];
            default: ;
         endcase
      end
   end

   // night mode only uses the low phase bit
   assign run_phase  = night_ff ? (phase_ff[0] ? PH_YELLOW : PH_GREEN) : phase_ff;
   assign load_ticks = night_ff ? nhalf_ff : len_data.ticks;
   assign cur_ticks  = fresh_ff ? load_ticks : ticks_ff;
   assign period     = (aper_ff == '0) ? ALERT_W'(1) : aper_ff;
   assign acnt_next  = acnt_ff + ALERT_W'(1);

   // next state
   always_comb begin
      phase_in = phase_ff;
      fresh_in = fresh_ff;
      ticks_in = ticks_ff;
      hold_in  = hold_ff;
      night_in = night_ff;
      pause_in = pause_ff;
      cnt_in   = cnt_ff;
      acnt_in  = acnt_ff;
      alert_in = 1'b0;
      if (len_data.btn) begin
         // hold the timer, count the press
         if (hold_ff != HOLD_MAX) hold_in = hold_ff + HOLD_W'(1);
      end else if (hold_ff != '0) begin
         if (hold_ff >= long_ff) begin
            night_in = !night_ff;
            pause_in = 1'b0;
            phase_in = PH_GREEN;
            fresh_in = 1'b1;
         end else if (pause_ff) begin
            pause_in = 1'b0;
            phase_in = PH_GREEN;
            fresh_in = 1'b1;
         end else begin
            pause_in = 1'b1;
         end
         hold_in = '0;
      end else if (!pause_ff) begin
         phase_in = run_phase;
         fresh_in = 1'b0;
         if (cur_ticks > TICKS_W'(1)) begin
            ticks_in = cur_ticks - TICKS_W'(1);
         end else begin
            ticks_in = '0;
            fresh_in = 1'b1;
            if (night_ff) begin
               phase_in = (run_phase == PH_GREEN) ? PH_YELLOW : PH_GREEN;
            end else begin
               case (run_phase)
                  PH_GREEN:  phase_in = PH_YELLOW;
                  PH_YELLOW: phase_in = PH_RED;
                  PH_RED: begin
                     cnt_in = cnt_ff + COUNT_BITS'(1);
                     if (acnt_next >= period) begin
                        acnt_in  = '0;
                        alert_in = 1'b1;
                     end else begin
                        acnt_in = acnt_next;
                     end
                     phase_in = PH_GREEN;
                  end
                  default: phase_in = PH_GREEN;
               endcase
            end
         end
      end
   end

   assign cnt_wide = 32'(cnt_in);

   // lamps: dark while paused and on the tick a press ends
   always_comb begin
      lamp_en                 = !pause_ff && (len_data.btn || hold_ff == '0);
      rsp_in.red_on           = lamp_en && !night_ff && run_phase == PH_RED;
      rsp_in.yellow_on        = lamp_en && (night_ff ? run_phase == PH_GREEN
                                                     : run_phase == PH_YELLOW);
      rsp_in.green_on         = lamp_en && !night_ff && run_phase == PH_GREEN;
      rsp_in.night_active     = night_in;
      rsp_in.is_paused        = pause_in;
      rsp_in.completed_cycles = cnt_wide[15:0];
      rsp_in.cycle_alert      = alert_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_GREEN;
         fresh_ff     <= 1'b1;
         ticks_ff     <= '0;
         hold_ff      <= '0;
         night_ff     <= 1'b0;
         pause_ff     <= 1'b0;
         cnt_ff       <= '0;
         acnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy_o) rsp_valid_ff <= len_valid;
         if (take) begin
            phase_ff <= phase_in;
            fresh_ff <= fresh_in;
            ticks_ff <= ticks_in;
            hold_ff  <= hold_in;
            night_ff <= night_in;
            pause_ff <= pause_in;
            cnt_ff   <= cnt_in;
            acnt_ff  <= acnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/tlc_checker.sv @@
// Port-level checks for the traffic light controller, bound to the top level.
module tlc_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tlc_pkg::tlc_rsp_type rsp_data
);
   import tlc_pkg::*;

   // a stalled result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
   else $error("result changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_paused |->
         !rsp_data.red_on && !rsp_data.yellow_on && !rsp_data.green_on)
   else $error("lamp lit while paused");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.night_active |-> !rsp_data.red_on && !rsp_data.green_on)
   else $error("red or green lit in night mode");

   // an alert only ends a red phase in normal mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cycle_alert |-> rsp_data.red_on && !rsp_data.night_active)
   else $error("alert outside the end of a red phase");

endmodule

bind traffic_light_controller tlc_checker u_tlc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the traffic light controller: random ticks in, lamp states and status fields checked.
module testbench;
   import tlc_pkg::*;

   localparam int          STEP_MS     = 50;
   localparam int          STEP_TICKS  = 5;
   localparam int unsigned MS_TOP      = 4000;
   localparam int unsigned DRAIN_TICKS = 12;
   localparam int unsigned MAX_PRINTS  = 40;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   tlc_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   tlc_rsp_type            rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   traffic_light_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // register copy
   logic [MS_W-1:0]    cfg_min_ms       = RST_INTERVAL_MIN;
   logic [MS_W-1:0]    cfg_max_ms       = RST_INTERVAL_MAX;
   logic [HOLD_W-1:0]  cfg_long_press   = RST_LONG_PRESS;
   logic [TICKS_W-1:0] cfg_night_half   = RST_NIGHT_HALF;
   logic [ALERT_W-1:0] cfg_alert_period = RST_ALERT_PERIOD;

   // light state copy
   logic [1:0]         lamp_phase  = PH_GREEN;
   logic               phase_fresh = 1'b1;
   logic [15:0]        ticks_left  = '0;
   logic [HOLD_W-1:0]  hold_ticks  = '0;
   logic               night_mode  = 1'b0;
   logic               paused      = 1'b0;
   logic [15:0]        cycle_total = '0;
   logic [ALERT_W-1:0] alert_count = '0;

   tlc_req_type tick_queue[$];
   tlc_rsp_type lamp_expect[$];
   tlc_rsp_type lamp_want;

   int unsigned n_queued   = 0;
   int unsigned n_results  = 0;
   int unsigned n_errors   = 0;
   int unsigned n_settings = 0;
   int unsigned n_toggles  = 0;
   int unsigned n_pauses   = 0;
   int unsigned n_alerts   = 0;
   bit          quiet      = 1'b0;
   int unsigned req_gap    = 0;
   int unsigned rsp_hold   = 0;

   task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
      n_errors++;
      if (n_errors <= MAX_PRINTS)
         $display("%0t: %s mismatch at result %0d: got %0h, want %0h",
                  $time, what, n_results, got, want);
   endtask

   function automatic int unsigned idle_draw();
      return quiet ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic logic [15:0] phase_length(logic [POT_BITS-1:0] pot);
      int span;
      int ms;
      span = int'(cfg_max_ms) - int'(cfg_min_ms);
      ms   = int'(cfg_min_ms) + (int'(pot) * span) / int'(POT_FULL);
      if (ms < 0) ms = 0;
      return 16'((ms / STEP_MS) * STEP_TICKS);
   endfunction

   // {red, yellow, green} for the current phase
   function automatic logic [2:0] phase_lamps();
      if (night_mode) return {1'b0, ~lamp_phase[0], 1'b0};
      return {lamp_phase == PH_RED, lamp_phase == PH_YELLOW, lamp_phase == PH_GREEN};
   endfunction

   function automatic tlc_rsp_type predict_tick(tlc_req_type t);
      tlc_rsp_type        r;
      logic [ALERT_W-1:0] period;
      r = '0;
      if (t.button_pressed) begin
         if (hold_ticks != HOLD_MAX) hold_ticks = hold_ticks + 1'b1;
         if (!paused) {r.red_on, r.yellow_on, r.green_on} = phase_lamps();
      end else if (hold_ticks != '0) begin
         // release tick: all lamps dark, timer idle
         if (hold_ticks >= cfg_long_press) begin
            night_mode  = ~night_mode;
            paused      = 1'b0;
            lamp_phase  = PH_GREEN;
            phase_fresh = 1'b1;
            n_toggles++;
         end else if (paused) begin
            paused      = 1'b0;
            lamp_phase  = PH_GREEN;
            phase_fresh = 1'b1;
         end else begin
            paused = 1'b1;
            n_pauses++;
         end
         hold_ticks = '0;
      end else if (!paused) begin
         if (night_mode) lamp_phase[1] = 1'b0;
         if (phase_fresh) begin
            ticks_left  = night_mode ? 16'(cfg_night_half) : phase_length(t.pot_level);
            phase_fresh = 1'b0;
         end
         {r.red_on, r.yellow_on, r.green_on} = phase_lamps();
         if (ticks_left > 16'd1) begin
            ticks_left = ticks_left - 1'b1;
         end else begin
            ticks_left  = '0;
            phase_fresh = 1'b1;
            if (night_mode) begin
               lamp_phase = lamp_phase[0] ? PH_GREEN : PH_YELLOW;
            end else if (lamp_phase >= PH_RED) begin
               if (lamp_phase == PH_RED) begin
                  period      = (cfg_alert_period == '0) ? 4'd1 : cfg_alert_period;
                  cycle_total = cycle_total + 1'b1;
                  alert_count = alert_count + 1'b1;
                  if (alert_count >= period) begin
                     alert_count   = '0;
                     r.cycle_alert = 1'b1;
                     n_alerts++;
                  end
               end
               lamp_phase = PH_GREEN;
            end else begin
               lamp_phase = lamp_phase + 1'b1;
            end
         end
      end
      r.night_active     = night_mode;
      r.is_paused        = paused;
      r.completed_cycles = cycle_total;
      return r;
   endfunction

   // tick driver: predict on each transfer, then idle for the drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) lamp_expect.push_back(predict_tick(req_data));
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (tick_queue.size() != 0) begin
               req_data  <= tick_queue.pop_front();
               req_valid <= 1'b1;
               req_gap   <= idle_draw();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (lamp_expect.size() == 0) begin
               note_mismatch("unexpected result", 16'd1, 16'd0);
            end else begin
               lamp_want = lamp_expect.pop_front();
               if (rsp_data.red_on !== lamp_want.red_on)
                  note_mismatch("red_on", 16'(rsp_data.red_on), 16'(lamp_want.red_on));
               if (rsp_data.yellow_on !== lamp_want.yellow_on)
                  note_mismatch("yellow_on", 16'(rsp_data.yellow_on),
                                16'(lamp_want.yellow_on));
               if (rsp_data.green_on !== lamp_want.green_on)
                  note_mismatch("green_on", 16'(rsp_data.green_on), 16'(lamp_want.green_on));
               if (rsp_data.night_active !== lamp_want.night_active)
                  note_mismatch("night_active", 16'(rsp_data.night_active),
                                16'(lamp_want.night_active));
               if (rsp_data.is_paused !== lamp_want.is_paused)
                  note_mismatch("is_paused", 16'(rsp_data.is_paused),
                                16'(lamp_want.is_paused));
               if (rsp_data.completed_cycles !== lamp_want.completed_cycles)
                  note_mismatch("completed_cycles", rsp_data.completed_cycles,
                                lamp_want.completed_cycles);
               if (rsp_data.cycle_alert !== lamp_want.cycle_alert)
                  note_mismatch("cycle_alert", 16'(rsp_data.cycle_alert),
                                16'(lamp_want.cycle_alert));
            end
            n_results++;
            rsp_hold = idle_draw();
         end
         if (rsp_hold != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [POT_BITS-1:0] draw_pot();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return POT_BITS'(POT_FULL);
         default: return POT_BITS'($urandom_range(0, POT_FULL));
      endcase
   endfunction

   task automatic add_tick(bit btn, logic [POT_BITS-1:0] pot);
      tlc_req_type t;
      t.button_pressed = btn;
      t.pot_level      = pot;
      tick_queue.push_back(t);
      n_queued++;
   endtask

   task automatic add_run(int unsigned n);
      repeat (n) add_tick(1'b0, draw_pot());
   endtask

   // n held ticks, then the release tick
   task automatic add_press(int unsigned n);
      repeat (n) add_tick(1'b1, draw_pot());
      add_tick(1'b0, draw_pot());
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      case (idx)
         CSR_INTERVAL_MIN: cfg_min_ms       = MS_W'(value);
         CSR_INTERVAL_MAX: cfg_max_ms       = MS_W'(value);
         CSR_LONG_PRESS:   cfg_long_press   = HOLD_W'(value);
         CSR_NIGHT_HALF:   cfg_night_half   = TICKS_W'(value);
         CSR_ALERT_PERIOD: cfg_alert_period = ALERT_W'(value);
         default: ;
      endcase
   endtask

   task automatic apply_settings(int unsigned lo_ms, int unsigned hi_ms, int unsigned press,
                                 int unsigned half, int unsigned period);
      write_reg(CSR_INTERVAL_MIN, lo_ms);
      write_reg(CSR_INTERVAL_MAX, hi_ms);
      write_reg(CSR_LONG_PRESS, press);
      write_reg(CSR_NIGHT_HALF, half);
      write_reg(CSR_ALERT_PERIOD, period);
      @(posedge clock);
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic wait_idle();
      while (n_results < n_queued) @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);
   endtask

   function automatic int unsigned pick_ms();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return MS_TOP;
         default: return $urandom_range(0, 400);
      endcase
   endfunction

   // mostly released runs and presses sized around the threshold, some raw noise
   task automatic random_phase(int unsigned budget);
      int unsigned start;
      int unsigned lp;
      start = n_queued;
      lp    = (cfg_long_press == '0) ? 1 : cfg_long_press;
      while (n_queued - start < budget) begin
         case ($urandom_range(0, 11))
            0:       repeat ($urandom_range(1, 6))
                        add_tick(1'($urandom_range(0, 1)), draw_pot());
            1, 2:    add_press($urandom_range(1, (lp > 1) ? lp - 1 : 1));
            3:       add_press($urandom_range(0, 1) ? lp : ((lp > 1) ? lp - 1 : 1));
            4:       add_press(lp + $urandom_range(0, 10));
            default: add_run($urandom_range(1, 80));
         endcase
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings, then pause with a short press
      add_tick(1'b0, '0);
      add_tick(1'b0, POT_BITS'(POT_FULL));
      add_press(1);
      wait_idle();

      // zero-length phases, zero night half, zero alert period
      apply_settings(0, 0, 3, 0, 0);
      add_press(1);
      add_run(4);
      add_press(1);
      add_run(1);
      add_press(3);
      add_run(3);
      add_press(4);
      add_tick(1'b0, '0);
      add_tick(1'b0, POT_BITS'(POT_FULL));
      wait_idle();

      for (int k = 0; k < 8; k++) begin
         quiet = ($urandom_range(0, 3) == 0);
         if (k == 0) begin
            apply_settings(int'(RST_INTERVAL_MIN), int'(RST_INTERVAL_MAX),
                           int'(RST_LONG_PRESS), int'(RST_NIGHT_HALF),
                           int'(RST_ALERT_PERIOD));
            random_phase(110);
         end else if (k == 3) begin
            // near the top of every range, min above max, hold long enough to saturate
            apply_settings(MS_TOP, 0, 1000, 1000, 15);
            add_run(30);
            add_press(20);
            add_run(10);
            add_press(int'(HOLD_MAX) + 3);
            add_run(40);
         end else begin
            apply_settings(pick_ms(), pick_ms(),
                           ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40),
                           ($urandom_range(0, 9) == 0) ? 0 :
                           ($urandom_range(0, 8) == 0) ? 1000 : $urandom_range(1, 25),
                           ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 15));
            random_phase(110);
         end
         wait_idle();
      end

      if (lamp_expect.size() != 0)
         note_mismatch("missing result", 16'(lamp_expect.size()), 16'd0);
      $display("Covered %0d ticks under %0d register settings, extremes and zero cases included.",
               n_queued, n_settings);
      $display("Saw %0d mode changes, %0d pauses, %0d alert pulses, %0d completed cycles.",
               n_toggles, n_pauses, n_alerts, cycle_total);
      if (n_errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Timed out with %0d of %0d results received", n_results, n_queued);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
